[rtl/string_to_tagged_int_parser_unit_assert.svh]
// Assertion macros for the string to tagged integer parser.
// Clocked on clk_i and disabled while rst_ni is low; used by the top level.
`ifndef STRING_TO_TAGGED_INT_PARSER_UNIT_ASSERT_SVH
`define STRING_TO_TAGGED_INT_PARSER_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define S2TP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define S2TP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/s2tp_pkg.sv]
// Shared constants for the string to tagged integer parser.
// Holds sign codes, character codes and the default value width; no dependencies.
package s2tp_pkg;

  localparam int unsigned VALUE_BITS_DEF = 31;

  // Sign codes
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_F  = 8'h46;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_X  = 8'h78;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

endpackage

[rtl/s2tp_digit_unit.sv]
// Digit step of the parser: decodes one character and folds it into the magnitude.
// Checks the limit before and after the multiply; depends on s2tp_pkg.
module s2tp_digit_unit
  import s2tp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [7:0]            char_i,
  input  logic                  hex_i,
  input  logic [1:0]            sign_i,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic                  fail_o
);

  localparam int unsigned WB = VALUE_BITS + 4;

  localparam logic [VALUE_BITS-1:0] LIM_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] LIM_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] LIM_HEX = {VALUE_BITS{1'b1}};

  localparam logic [VALUE_BITS-1:0] THR_MAX_DEC = VALUE_BITS'(LIM_MAX / 10);
  localparam logic [VALUE_BITS-1:0] THR_MAX_HEX = VALUE_BITS'(LIM_MAX / 16);
  localparam logic [VALUE_BITS-1:0] THR_NEG_DEC = VALUE_BITS'(LIM_NEG / 10);
  localparam logic [VALUE_BITS-1:0] THR_NEG_HEX = VALUE_BITS'(LIM_NEG / 16);
  localparam logic [VALUE_BITS-1:0] THR_HEX_HEX = VALUE_BITS'(LIM_HEX / 16);

  logic [VALUE_BITS-1:0] lim;
  logic [VALUE_BITS-1:0] thr;
  logic [7:0]            up;
  logic                  is_dec;
  logic                  is_hex;
  logic [3:0]            digit;
  logic [WB-1:0]         acc_ext;
  logic [WB-1:0]         prod;
  logic [WB-1:0]         sum;

  // Pick the limit and the pre-multiply threshold for this sign and radix
  always_comb begin
    case (sign_i)
      SIGN_MINUS: begin
        lim = LIM_NEG;
        thr = hex_i ? THR_NEG_HEX : THR_NEG_DEC;
      end
      SIGN_PLUS: begin
        lim = LIM_MAX;
        thr = hex_i ? THR_MAX_HEX : THR_MAX_DEC;
      end
      default: begin
        lim = hex_i ? LIM_HEX : LIM_MAX;
        thr = hex_i ? THR_HEX_HEX : THR_MAX_DEC;
      end
    endcase
  end

  // Fold case and decode the digit
  assign up     = (char_i >= CH_LOWER_A && char_i <= CH_LOWER_Z) ? char_i - CASE_OFFSET
                                                                   : char_i;
  assign is_dec = (up >= CH_ZERO) && (up <= CH_NINE);
  assign is_hex = hex_i && (up >= CH_UPPER_A) && (up <= CH_UPPER_F);
  assign digit  = is_dec ? up[3:0] : 4'(up[3:0] + 4'd9);

  // Multiply by the radix with shifts, then add the digit
  assign acc_ext = {4'b0000, acc_i};
  assign prod    = hex_i ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
  assign sum     = prod + {{(WB-4){1'b0}}, digit};

  assign fail_o = (acc_i > thr) || !(is_dec || is_hex) || (sum > {4'b0000, lim});
  assign acc_o  = sum[VALUE_BITS-1:0];

endmodule

[rtl/string_to_tagged_int_parser_unit.sv]
// Top level of the string to tagged integer parser: input register, parse
// state, result register and flow control. Depends on s2tp_pkg, s2tp_digit_unit
// and the assertion macro header.
//
// Usage:
//   Characters arrive on the input channel (in_valid_i, in_stall_o, char_code_i),
//   one per request. A NUL character ends the string and produces one result on
//   the output channel (out_valid_o, out_stall_i, ok_o, value_o); every other
//   character produces none. Leading blanks, an optional sign and a "0x" prefix
//   are handled; ok_o is 0 and value_o is 0 for a malformed or out-of-range string.
//   Throughput: one character per cycle, including back-to-back strings, while no NUL
//   waits on an untaken result. A NUL accepted into the input register loads its result
//   into the result register as soon as that register is free or being taken.
//   The character step is a shift-add multiply, an add and a limit compare,
//   done combinationally between the input register and the parse state registers.
//   Stall: while a result waits untaken, plain characters keep flowing; a next
//   NUL holds in the input register, and in_stall_o rises, until the result is taken.
//   Reset: asynchronous, active low; clears the parse state and both valid flags.
module string_to_tagged_int_parser_unit
  import s2tp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic signed [31:0] value_o
);

`include "string_to_tagged_int_parser_unit_assert.svh"

  // Parse phases
  localparam logic [2:0] PH_WS    = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_ZERO  = 3'd2;
  localparam logic [2:0] PH_HEX0  = 3'd3;
  localparam logic [2:0] PH_DIG   = 3'd4;

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            char_q;
  logic [2:0]            phase_q, phase_d;
  logic [1:0]            sign_q, sign_d;
  logic                  hex_q, hex_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  failed_q, failed_d;
  logic                  out_valid_q, out_valid_d;
  logic                  ok_q, ok_d;
  logic [31:0]           value_q, value_d;

  logic                  fire;
  logic                  is_nul;
  logic                  is_ws;
  logic                  dig_fail;
  logic [VALUE_BITS-1:0] dig_acc;
  logic                  ok_n;
  logic                  ext_bit;
  logic [31:0]           mag;

  // Digit decode, limit check and multiply-add
  s2tp_digit_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digit (
    .acc_i  (acc_q),
    .char_i (char_q),
    .hex_i  (hex_q),
    .sign_i (sign_q),
    .acc_o  (dig_acc),
    .fail_o (dig_fail)
  );

  // Process a held request; a NUL needs a free result register
  assign is_nul     = (char_q == CH_NUL);
  assign fire       = in_valid_q && (!is_nul || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign is_ws      = (char_q == CH_SPACE) || ((char_q >= CH_TAB) && (char_q <= CH_CR));

  // Form the result value from the magnitude
  assign ok_n    = !failed_q && ((phase_q == PH_ZERO) || (phase_q == PH_DIG));
  assign ext_bit = (sign_q == SIGN_NONE) && acc_q[VALUE_BITS-1];
  assign mag     = {{(32-VALUE_BITS){ext_bit}}, acc_q};

  // Advance the input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  // Step the parse state and load the result
  always_comb begin
    phase_d     = phase_q;
    sign_d      = sign_q;
    hex_d       = hex_q;
    acc_d       = acc_q;
    failed_d    = failed_q;
    ok_d        = ok_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      if (is_nul) begin
        out_valid_d = 1'b1;
        ok_d        = ok_n;
        if (!ok_n) begin
          value_d = 32'd0;
        end else if (sign_q == SIGN_MINUS) begin
          value_d = 32'd0 - mag;
        end else begin
          value_d = mag;
        end
        phase_d  = PH_WS;
        sign_d   = SIGN_NONE;
        hex_d    = 1'b0;
        acc_d    = '0;
        failed_d = 1'b0;
      end else if (!failed_q) begin
        case (phase_q)
          PH_WS: begin
            if (is_ws) begin
              phase_d = PH_WS;
            end else if (char_q == CH_PLUS || char_q == CH_MINUS) begin
              sign_d  = (char_q == CH_MINUS) ? SIGN_MINUS : SIGN_PLUS;
              phase_d = PH_START;
            end else if (char_q == CH_ZERO) begin
              phase_d = PH_ZERO;
            end else begin
              failed_d = dig_fail;
              acc_d    = dig_fail ? acc_q : dig_acc;
              phase_d  = PH_DIG;
            end
          end
          PH_START: begin
            if (char_q == CH_ZERO) begin
              phase_d = PH_ZERO;
            end else begin
              failed_d = dig_fail;
              acc_d    = dig_fail ? acc_q : dig_acc;
              phase_d  = PH_DIG;
            end
          end
          PH_ZERO: begin
            if (char_q == CH_LOWER_X) begin
              hex_d   = 1'b1;
              phase_d = PH_HEX0;
            end else begin
              failed_d = dig_fail;
              acc_d    = dig_fail ? acc_q : dig_acc;
              phase_d  = PH_DIG;
            end
          end
          default: begin
            failed_d = dig_fail;
            acc_d    = dig_fail ? acc_q : dig_acc;
            phase_d  = PH_DIG;
          end
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_WS;
      sign_q      <= SIGN_NONE;
      hex_q       <= 1'b0;
      acc_q       <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      phase_q     <= phase_d;
      sign_q      <= sign_d;
      hex_q       <= hex_d;
      acc_q       <= acc_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_code_i;
    end
    ok_q    <= ok_d;
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign value_o     = value_q;

  // Checks
  `S2TP_ASSERT_SAME(a_fail_value_zero, out_valid_o && !ok_o, value_o == 32'd0, "failed result carries a nonzero value")
  `S2TP_ASSERT_NEXT(a_nul_resets_state, fire && is_nul, phase_q == PH_WS && acc_q == '0 && !failed_q && !hex_q && sign_q == SIGN_NONE, "parse state not cleared after NUL")
  `S2TP_ASSERT_NEXT(a_nul_gives_result, fire && is_nul, out_valid_o, "NUL did not produce a result")
  `S2TP_ASSERT_NEXT(a_error_latched, failed_q && !(fire && is_nul), failed_q, "error dropped before NUL")

endmodule

[bench/tb_string_to_tagged_int_parser_unit.sv]
// Testbench for string_to_tagged_int_parser_unit: streams character strings in, predicts
// each NUL result in step, and compares ok_o/value_o. Depends on s2tp_pkg and the RTL top.
module tb_string_to_tagged_int_parser_unit;
  import s2tp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VB = VALUE_BITS_DEF;
  localparam logic [31:0] MAG_MAX = (32'd1 << (VB - 1)) - 32'd1;
  localparam logic [31:0] RADIX_DEC = 32'd10;
  localparam logic [31:0] RADIX_HEX = 32'd16;
  localparam int ITEMS_TARGET = 1200;
  localparam int HOLD_CYCLES = 300;
  // no request moves for at most a hold-off plus a few random stalls
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_LIMIT = 1000;
  localparam int MAX_SHOWN = 10;

  typedef enum logic [2:0] {
    SCAN_BLANK, SCAN_SIGNED, SCAN_ZERO, SCAN_HEX_PREFIX, SCAN_DIGITS
  } scan_phase_e;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } parse_result_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_i = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               ok_o;
  logic signed [31:0] value_o;

  // predicted parse state
  scan_phase_e scan_phase;
  logic [1:0]  sign_seen;
  logic        hex_radix;
  logic [31:0] magnitude;
  logic        parse_error;

  parse_result_t results_due[$];
  logic [7:0]    text_q[$];
  int            chars_sent = 0;
  int            mismatches = 0;
  bit            no_gaps = 1'b0;
  bit            hold_req = 1'b0;
  int            hold_left = 0;

  string_to_tagged_int_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .value_o    (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] limit_for(input logic [1:0] sgn, input logic hex);
    if (sgn == SIGN_MINUS) return MAG_MAX + 32'd1;
    if (sgn == SIGN_PLUS) return MAG_MAX;
    return hex ? ((MAG_MAX << 1) | 32'd1) : MAG_MAX;
  endfunction

  function automatic void clear_parse_state();
    scan_phase  = SCAN_BLANK;
    sign_seen   = SIGN_NONE;
    hex_radix   = 1'b0;
    magnitude   = 32'd0;
    parse_error = 1'b0;
  endfunction

  // Fold one digit into the magnitude; latch an error on overflow or a bad digit.
  function automatic void fold_digit(input logic [7:0] ch);
    logic [31:0] radix;
    logic [31:0] lim;
    logic [31:0] digit;
    logic [31:0] next_mag;
    logic [7:0]  up;
    radix = hex_radix ? RADIX_HEX : RADIX_DEC;
    lim = limit_for(sign_seen, hex_radix);
    up = ch;
    if (magnitude > lim / radix) begin
      parse_error = 1'b1;
      return;
    end
    if (up >= CH_LOWER_A && up <= CH_LOWER_Z) up = up - CASE_OFFSET;
    if (up >= CH_ZERO && up <= CH_NINE) begin
      digit = 32'(up - CH_ZERO);
    end else if (hex_radix && up >= CH_UPPER_A && up <= CH_UPPER_F) begin
      digit = 32'(up - CH_UPPER_A) + 32'd10;
    end else begin
      parse_error = 1'b1;
      return;
    end
    next_mag = magnitude * radix + digit;
    if (next_mag > lim) parse_error = 1'b1;
    else magnitude = next_mag;
  endfunction

  function automatic void first_digit(input logic [7:0] ch);
    if (ch == CH_ZERO) begin
      scan_phase = SCAN_ZERO;
    end else begin
      hex_radix = 1'b0;
      fold_digit(ch);
      scan_phase = SCAN_DIGITS;
    end
  endfunction

  // Advance the predicted state by one accepted character; queue a result on NUL.
  function automatic void predict_parse_char(input logic [7:0] ch);
    parse_result_t res;
    if (ch == CH_NUL) begin
      res.ok = !parse_error && (scan_phase == SCAN_ZERO || scan_phase == SCAN_DIGITS);
      res.value = 32'd0;
      if (res.ok) begin
        res.value = magnitude;
        if (sign_seen == SIGN_NONE && (res.value & (MAG_MAX + 32'd1)) != 0)
          res.value = res.value | ~((MAG_MAX << 1) | 32'd1);
        if (sign_seen == SIGN_MINUS) res.value = 32'd0 - res.value;
      end
      results_due.push_back(res);
      clear_parse_state();
      return;
    end
    if (parse_error) return;
    case (scan_phase)
      SCAN_BLANK: begin
        if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
          // skip leading blank
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
          sign_seen = (ch == CH_MINUS) ? SIGN_MINUS : SIGN_PLUS;
          scan_phase = SCAN_SIGNED;
        end else begin
          first_digit(ch);
        end
      end
      SCAN_SIGNED: first_digit(ch);
      SCAN_ZERO: begin
        if (ch == CH_LOWER_X) begin
          hex_radix = 1'b1;
          scan_phase = SCAN_HEX_PREFIX;
        end else begin
          hex_radix = 1'b0;
          fold_digit(CH_ZERO);
          if (!parse_error) fold_digit(ch);
          scan_phase = SCAN_DIGITS;
        end
      end
      default: begin
        fold_digit(ch);
        scan_phase = SCAN_DIGITS;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------ driving

  // Offer one character, wait for the request to be taken, then predict.
  task automatic send_char(input logic [7:0] ch);
    while (!no_gaps && $urandom_range(99) < 19) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    char_code_i <= ch;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_parse_char(ch);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
    send_char(CH_NUL);
  endtask

  function automatic void load_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Pick a magnitude that lands on, just below, just past or well past the limit, or anywhere.
  function automatic logic [63:0] pick_magnitude(input logic [1:0] sgn, input logic hex);
    logic [63:0] lim;
    logic [63:0] radix;
    lim = 64'(limit_for(sgn, hex));
    radix = hex ? 64'(RADIX_HEX) : 64'(RADIX_DEC);
    case ($urandom_range(7))
      0: return lim;
      1: return lim + 64'd1;
      2: return lim - 64'($urandom_range(20));
      3: return 64'(MAG_MAX) + 64'd1;
      4: return {$urandom, $urandom} >> $urandom_range(24, 63);
      5: return 64'($urandom_range(999));
      6: return 64'($urandom);
      default: return (lim / radix + 64'd1) * radix + 64'($urandom_range(15));
    endcase
  endfunction

  // Build a mostly well-formed number string, with occasional damage.
  function automatic void make_number_text();
    logic [1:0]  sgn;
    logic        hex;
    logic        upper;
    logic [63:0] mag;
    logic [7:0]  ch;
    string       digits;
    text_q.delete();
    sgn = 2'($urandom_range(2));
    hex = 1'($urandom_range(1));
    upper = 1'($urandom_range(1));
    repeat ($urandom_range(3)) begin
      if ($urandom_range(1)) text_q.push_back(CH_SPACE);
      else text_q.push_back(CH_TAB + 8'($urandom_range(4)));
    end
    if (sgn == SIGN_PLUS) text_q.push_back(CH_PLUS);
    if (sgn == SIGN_MINUS) text_q.push_back(CH_MINUS);
    if (hex) begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(14) == 0 ? CH_LOWER_X - CASE_OFFSET : CH_LOWER_X);
    end
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(CH_ZERO);
    if ($urandom_range(19) != 0) begin
      mag = pick_magnitude(sgn, hex);
      digits = hex ? $sformatf("%0h", mag) : $sformatf("%0d", mag);
      for (int i = 0; i < digits.len(); i++) begin
        ch = digits[i];
        if (upper && ch >= CH_LOWER_A) ch = ch - CASE_OFFSET;
        text_q.push_back(ch);
      end
    end
    if ($urandom_range(9) == 0 && text_q.size() != 0)
      text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(1, 255));
  endfunction

  function automatic void make_noise_text();
    text_q.delete();
    repeat ($urandom_range(6)) text_q.push_back(8'($urandom_range(1, 255)));
  endfunction

  // ----------------------------------------------------------- output side

  // Hold the output for a long stretch on request, otherwise stall at random.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_gaps && ($urandom_range(99) < 19);
      end
    end
  end

  // Compare each taken result with the oldest prediction.
  initial begin
    parse_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (results_due.size() == 0) begin
          note_failure($sformatf("result ok=%0b value=%0d with nothing pending",
                                 ok_o, value_o));
        end else begin
          want = results_due.pop_front();
          if (ok_o !== want.ok || value_o !== want.value)
            note_failure($sformatf("expected ok=%0b value=%0d, got ok=%0b value=%0d",
                                   want.ok, $signed(want.value), ok_o, value_o));
        end
      end
    end
  end

  // End the run when no request moves on either side for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) stuck = 0;
      else stuck++;
    end
    $display("Timeout: no request moved for %0d cycles", STUCK_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // -------------------------------------------------------------------- tests

  // Blanks, signs, prefix forms, mixed-case hex, limits and bad characters.
  task automatic test_directed_strings();
    load_text("");            send_text();
    load_text("\t +0");       send_text();
    load_text("-");           send_text();
    load_text("0x");          send_text();
    load_text("0X1");         send_text();
    load_text("0xaF");        send_text();
    load_text("0x7fffffff");  send_text();
    load_text("-1073741824"); send_text();
    load_text("+1073741824"); send_text();
    load_text("1a");          send_text();
    load_text("12 ");         send_text();
    text_q = '{CH_SPACE, 8'hFF, CH_NINE};
    send_text();
  endtask

  // Run both sides with no gaps at all.
  task automatic test_back_to_back_strings();
    no_gaps = 1'b1;
    repeat (30) begin
      make_number_text();
      send_text();
    end
    no_gaps = 1'b0;
  endtask

  // Hold the output while short strings keep coming, so the input stalls.
  task automatic test_output_hold_off();
    no_gaps = 1'b1;
    hold_req = 1'b1;
    repeat (6) begin
      load_text($sformatf("%0d", $urandom_range(99)));
      send_text();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_strings();
    while (chars_sent < ITEMS_TARGET) begin
      if ($urandom_range(9) < 8) make_number_text();
      else make_noise_text();
      send_text();
    end
  endtask

  initial begin
    clear_parse_state();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_strings();
    test_back_to_back_strings();
    test_output_hold_off();
    test_random_strings();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && results_due.size() != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (results_due.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", results_due.size()));

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
